>>> rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types, tables and round functions for the AES-128 pipeline
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int BLOCK_W  = 128;
  localparam int HALF_W   = 64;
  localparam int NUM_RND  = 10;
  localparam int RND_IDX_W = 4;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

  typedef enum logic {CMD_ENC = 1'b0, CMD_DEC = 1'b1} cmd_t;

  typedef struct packed {
    logic         vld;
    cmd_t         cmd;
    logic [127:0] st;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [RND_IDX_W-1:0] r);
    case (r)
      4'd0: return 8'h01;
      4'd1: return 8'h02;
      4'd2: return 8'h04;
      4'd3: return 8'h08;
      4'd4: return 8'h10;
      4'd5: return 8'h20;
      4'd6: return 8'h40;
      4'd7: return 8'h80;
      4'd8: return 8'h1b;
      4'd9: return 8'h36;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state, FIPS order, byte 0 in bits 127:120
  function automatic logic [7:0] gb(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] next_rk(input logic [127:0] k,
                                            input logic [RND_IDX_W-1:0] r);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    t  = t ^ {rcon(r), 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sbox(gb(s, 4*c));
      a1 = sbox(gb(s, 4*((c+1)%4)+1));
      a2 = sbox(gb(s, 4*((c+2)%4)+2));
      a3 = sbox(gb(s, 4*((c+3)%4)+3));
      if (last) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {xt(a0)^xt(a1)^a1^a2^a3, a0^xt(a1)^xt(a2)^a2^a3,
                             a0^a1^xt(a2)^xt(a3)^a3, xt(a0)^a0^a1^a2^xt(a3)};
      end
    end
    return o;
  endfunction

  // inverse round after AddRoundKey: InvMixColumns (unless skipped), InvShiftRows, InvSubBytes
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic nomix);
    logic [127:0] m, o;
    logic [7:0] b0, b1, b2, b3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    m = s;
    if (!nomix) begin
      for (int c = 0; c < 4; c++) begin
        b0 = gb(s, 4*c); b1 = gb(s, 4*c+1); b2 = gb(s, 4*c+2); b3 = gb(s, 4*c+3);
        x0 = xt(b0); x1 = xt(b1); x2 = xt(b2); x3 = xt(b3);
        y0 = xt(x0); y1 = xt(x1); y2 = xt(x2); y3 = xt(x3);
        z0 = xt(y0); z1 = xt(y1); z2 = xt(y2); z3 = xt(y3);
        m[127-32*c -: 32] = {
          z0^y0^x0 ^ z1^x1^b1 ^ z2^y2^b2 ^ z3^b3,
          z0^b0 ^ z1^y1^x1 ^ z2^x2^b2 ^ z3^y3^b3,
          z0^y0^b0 ^ z1^b1 ^ z2^y2^x2 ^ z3^x3^b3,
          z0^x0^b0 ^ z1^y1^b1 ^ z2^b2 ^ z3^y3^x3};
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(gb(m, r+4*c));
      end
    end
    return o;
  endfunction

endpackage

>>> rtl/aes_if.sv
// ----------------------------------------------------------------------------
// aes_if: valid/ready channel carrying one item of width W
// ----------------------------------------------------------------------------
interface aes_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/aes_cell.sv
// ----------------------------------------------------------------------------
// aes_cell: one round of the cipher chain
// Each cell holds one item and its own round keys; both advance together.
// ----------------------------------------------------------------------------
module aes_cell
  import aes_pkg::*;
#(
  parameter logic [RND_IDX_W-1:0] RND = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  stage_t        s_in,
  input  logic [127:0]  ek_in,
  input  logic [127:0]  dk_in,
  output stage_t        s_out,
  output logic [127:0]  ek_out,
  output logic [127:0]  dk_out
);
  // ek: forward key schedule; dk runs back from round key 10 to 0
  stage_t       s_r, s_nxt;
  logic [127:0] ek_r, ek_nxt, dk_r, dk_nxt, ek_new, dk_new;

  always_comb begin
    ek_new = next_rk(ek_in, RND);
    dk_new = dk_in;
    // inverse step of the schedule: recover previous key from current
    dk_new[31:0]  = dk_in[31:0] ^ dk_in[63:32];
    dk_new[63:32] = dk_in[63:32] ^ dk_in[95:64];
    dk_new[95:64] = dk_in[95:64] ^ dk_in[127:96];
    dk_new[127:96] = dk_in[127:96] ^ {sbox(dk_new[23:16]), sbox(dk_new[15:8]),
                                      sbox(dk_new[7:0]), sbox(dk_new[31:24])}
                     ^ {rcon(RND_IDX_W'(NUM_RND-1) - RND), 24'h0};
    s_nxt     = s_in;
    if (s_in.cmd == CMD_ENC) begin
      s_nxt.st = enc_round(s_in.st, RND == RND_IDX_W'(NUM_RND-1)) ^ ek_new;
    end else begin
      s_nxt.st = dec_round(s_in.st, RND == '0) ^ dk_new;
    end
    ek_nxt = ek_new;
    dk_nxt = dk_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (adv) begin
      s_r.vld <= s_nxt.vld;
    end
    if (adv) begin
      s_r.cmd <= s_nxt.cmd;
      s_r.st  <= s_nxt.st;
      ek_r    <= ek_nxt;
      dk_r    <= dk_nxt;
    end
  end

  assign s_out  = s_r;
  assign ek_out = ek_r;
  assign dk_out = dk_r;
endmodule

>>> rtl/aes128_block_cipher.sv
// A block passes the entry key-add stage and then the 10 round cells in turn,
// each a register stage, before its result is offered on out_ch.
// Throughput: one block per cycle outside stalls; each cell holds an item and its keys.
// After reset and after each key write, the block will hold the input off while round key 10
// is derived one schedule step per cycle; otherwise the chain stalls only when out is full.
// Reset (rst_n low, synchronous) drops all items in flight and clears the key to zero.
// ----------------------------------------------------------------------------
// aes128_block_cipher: AES-128 encrypt/decrypt pipeline
// A row of ten round cells; key schedule runs alongside the data.
// ----------------------------------------------------------------------------
module aes128_block_cipher
  import aes_pkg::*;
(
  input logic clk,
  input logic rst_n,
  aes_if.sink in_ch,
  aes_if.sink cfg_ch,
  aes_if.source out_ch
);
  logic [63:0]  key_high_r, key_low_r;
  logic [127:0] key, key_wr;
  logic         cfg_wr;
  stage_t       s0_r;
  logic [127:0] ek0_r, dk0_r;
  logic         adv;

  // round key 10 walker: one schedule step per cycle
  logic [127:0]          kr_r, kr_nxt;
  logic [RND_IDX_W-1:0]  kcnt_r, kcnt_nxt;
  logic                  kbusy_r, kbusy_nxt;

  stage_t       sc [NUM_RND+1];
  logic [127:0] ek [NUM_RND+1];
  logic [127:0] dk [NUM_RND+1];

  logic         in_cmd;
  logic [127:0] in_blk;

  // the chain advances unless the last cell holds an item nobody takes
  assign adv = !sc[NUM_RND].vld || out_ch.ready;
  // hold new items off while round key 10 is still being derived
  assign in_ch.ready  = adv && !kbusy_r;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  assign in_cmd = in_ch.data[128];
  assign in_blk = in_ch.data[127:0];
  assign key    = {key_high_r, key_low_r};

  // key as it stands after the current write
  always_comb begin
    key_wr = key;
    case (cfg_ch.data[64])
      CFG_KEY_HIGH: key_wr[127:64] = cfg_ch.data[63:0];
      CFG_KEY_LOW:  key_wr[63:0]   = cfg_ch.data[63:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      key_high_r <= key_wr[127:64];
      key_low_r  <= key_wr[63:0];
    end
  end

  // restart the walk on every key write; advance one round key per cycle until key 10
  always_comb begin
    kr_nxt    = kr_r;
    kcnt_nxt  = kcnt_r;
    kbusy_nxt = kbusy_r;
    if (cfg_wr) begin
      kr_nxt    = key_wr;
      kcnt_nxt  = '0;
      kbusy_nxt = 1'b1;
    end else if (kbusy_r) begin
      kr_nxt    = next_rk(kr_r, kcnt_r);
      kcnt_nxt  = kcnt_r + RND_IDX_W'(1);
      kbusy_nxt = (kcnt_r != RND_IDX_W'(NUM_RND-1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kr_r    <= '0;
      kcnt_r  <= '0;
      kbusy_r <= 1'b1;
    end else begin
      kr_r    <= kr_nxt;
      kcnt_r  <= kcnt_nxt;
      kbusy_r <= kbusy_nxt;
    end
  end

  // entry stage: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (adv) begin
      s0_r.vld <= in_ch.valid && !kbusy_r;
    end
    if (adv) begin
      s0_r.cmd <= cmd_t'(in_cmd);
      s0_r.st  <= in_blk ^ ((in_cmd == CMD_DEC) ? kr_r : key);
      ek0_r    <= key;
      dk0_r    <= kr_r;
    end
  end

  assign sc[0] = s0_r;
  assign ek[0] = ek0_r;
  assign dk[0] = dk0_r;

  for (genvar g = 0; g < NUM_RND; g++) begin : g_cell
    aes_cell #(.RND(RND_IDX_W'(g))) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .s_in(sc[g]), .ek_in(ek[g]), .dk_in(dk[g]),
      .s_out(sc[g+1]), .ek_out(ek[g+1]), .dk_out(dk[g+1])
    );
  end

  assign out_ch.valid = sc[NUM_RND].vld;
  assign out_ch.data  = sc[NUM_RND].st;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while chain stalled");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && out_ch.ready ##1 out_ch.ready ##1 out_ch.ready
    ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready
    ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready |=> out_ch.valid)
    else $error("item lost in chain");
`endif
endmodule

>>> tb/aes128_block_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_checker: AES-128 result predictor and comparator
// Watches the key, block and result channels, computes each expected
// result from its own cipher tables and compares results in order.
// ----------------------------------------------------------------------------
module aes128_block_cipher_checker
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [128:0] in_data,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [64:0]  cfg_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [127:0] out_data,
  output int           errors,
  output int           pending,
  output int           enc_cnt,
  output int           dec_cnt,
  output int           key_writes
);

  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];
  logic [63:0]  key_hi, key_lo;
  logic [127:0] expected_blocks [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // Build the substitution tables from the field inverse and the affine map.
  initial begin
    logic [7:0] v, s;
    for (int a = 0; a < 256; a++) begin
      v = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) v = b[7:0];
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]}
          ^ 8'h63;
      fwd_sub[a] = s;
      inv_sub[s] = a[7:0];
    end
  end

  function automatic logic [127:0] aes_block(input cmd_t op, input logic [127:0] blk,
                                             input logic [127:0] key);
    logic [127:0] rk [11];
    logic [127:0] s, t;
    logic [31:0]  w [44];
    logic [31:0]  x;
    logic [7:0]   rc, col [4], acc;
    logic [7:0]   mf [4], mi [4];
    mf = '{8'd2, 8'd3, 8'd1, 8'd1};
    mi = '{8'd14, 8'd11, 8'd13, 8'd9};
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      x = w[i-1];
      if (i % 4 == 0) begin
        x = {x[23:0], x[31:24]};
        x = {fwd_sub[x[31:24]] ^ rc, fwd_sub[x[23:16]], fwd_sub[x[15:8]], fwd_sub[x[7:0]]};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ x;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    s = blk;
    if (op == CMD_ENC) begin
      s ^= rk[0];
      for (int r = 1; r <= 10; r++) begin
        // substitute and rotate rows in one pass
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++)
            t[127-8*(j+4*c) -: 8] = fwd_sub[s[127-8*(j+4*((c+j)%4)) -: 8]];
        s = t;
        if (r != 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[127-8*(4*c+k) -: 8];
            for (int j = 0; j < 4; j++) begin
              acc = 8'h00;
              for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], mf[(k-j+4)%4]);
              s[127-8*(4*c+j) -: 8] = acc;
            end
          end
        end
        s ^= rk[r];
      end
    end else begin
      for (int r = 10; r >= 1; r--) begin
        s ^= rk[r];
        if (r != 10) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[127-8*(4*c+k) -: 8];
            for (int j = 0; j < 4; j++) begin
              acc = 8'h00;
              for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], mi[(k-j+4)%4]);
              s[127-8*(4*c+j) -: 8] = acc;
            end
          end
        end
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++)
            t[127-8*(j+4*((c+j)%4)) -: 8] = inv_sub[s[127-8*(j+4*c) -: 8]];
        s = t;
      end
      s ^= rk[0];
    end
    return s;
  endfunction

  always @(posedge clk) begin
    logic [127:0] want;
    cmd_t         op;
    if (!rst_n) begin
      key_hi <= '0;
      key_lo <= '0;
      expected_blocks.delete();
      errors     <= 0;
      pending    <= 0;
      enc_cnt    <= 0;
      dec_cnt    <= 0;
      key_writes <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_data[64] == CFG_KEY_HIGH) key_hi <= cfg_data[63:0];
        else key_lo <= cfg_data[63:0];
        key_writes <= key_writes + 1;
      end
      if (in_valid && in_ready) begin
        op = cmd_t'(in_data[128]);
        expected_blocks.push_back(aes_block(op, in_data[127:0], {key_hi, key_lo}));
        if (op == CMD_DEC) dec_cnt <= dec_cnt + 1;
        else enc_cnt <= enc_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time, out_data[127:64], out_data[63:0]);
          errors <= errors + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_data[127:64] !== want[127:64]) begin
            $display("%0t: result_high expected %h actual %h", $time, want[127:64],
                     out_data[127:64]);
            errors <= errors + 1;
          end else if (out_data[63:0] !== want[63:0]) begin
            $display("%0t: result_low expected %h actual %h", $time, want[63:0],
                     out_data[63:0]);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_blocks.size();
    end
  end

endmodule

>>> tb/aes128_block_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_tb: stimulus and verdict for the AES-128 pipeline
// Loads keys between phases, streams encrypt and decrypt items with random
// gaps and output stalls, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module aes128_block_cipher_tb
  import aes_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PIPE_LATENCY   = 11;

  logic clk = 1'b0;
  logic rst_n;
  int   errors, pending, enc_cnt, dec_cnt, key_writes;
  int   idle_cycles;
  bit   stall_free;  // when set, the result side never stalls

  aes_if #(.W(129)) in_ch ();
  aes_if #(.W(65))  cfg_ch ();
  aes_if #(.W(128)) out_ch ();

  aes128_block_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  aes128_block_cipher_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .errors     (errors),
    .pending    (pending),
    .enc_cnt    (enc_cnt),
    .dec_cnt    (dec_cnt),
    .key_writes (key_writes)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Bias toward edge patterns so every bit sees both values and extremes show up.
  function automatic logic [63:0] pick_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // Hold valid until the block takes the item; drop it only when a gap follows.
  task automatic send_block(input cmd_t op, input logic [63:0] hi, input logic [63:0] lo,
                            input bit use_gaps);
    int gap;
    gap = use_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {op, hi, lo};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drain the pipe completely before touching the key.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || out_ch.valid) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Leave valid high; the caller drops it once its writes are done.
  task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, val};
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_key(input logic [127:0] key);
    drain();
    write_key(CFG_KEY_HIGH, key[127:64]);
    write_key(CFG_KEY_LOW, key[63:0]);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic [63:0] hi, lo;
    bit          gaps;
    for (int i = 0; i < count; i++) begin
      // switch at random between stretches with and without gaps on the sender
      if (i % 64 == 0) gaps = ($urandom_range(0, 3) != 0);
      hi = pick_half();
      lo = pick_half();
      send_block(cmd_t'($urandom_range(0, 1)), hi, lo, gaps);
    end
  endtask

  // Result side: random stalls, with stretches of full-rate acceptance.
  always @(posedge clk) begin
    int stall;
    if (!stall_free && $urandom_range(0, 3) == 0) begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
    out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                   (cfg_ch.valid && cfg_ch.ready))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, nothing accepted", $time);
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    idle_cycles  <= 0;
    stall_free   <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    out_ch.ready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero key straight out of reset.
    send_block(CMD_ENC, '0, '0, 1'b0);
    send_block(CMD_DEC, '0, '0, 1'b0);
    send_block(CMD_ENC, '1, '1, 1'b0);
    send_block(CMD_DEC, '1, '1, 1'b0);

    // Standard test vector key 000102..0f, plaintext 00112233..ff and its ciphertext.
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    send_block(CMD_ENC, '0, '1, 1'b1);
    send_block(CMD_DEC, '1, '0, 1'b1);
    send_block(CMD_ENC, 64'h8000000000000000, 64'h1, 1'b1);

    // All-ones key, then back to all zeros written explicitly.
    load_key('1);
    send_block(CMD_ENC, '0, '0, 1'b0);
    send_block(CMD_DEC, '0, '0, 1'b0);
    send_block(CMD_ENC, '1, '1, 1'b0);
    send_block(CMD_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    load_key('0);
    send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(CMD_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);

    // Change only one key half to check that each register lands on its own.
    drain();
    write_key(CFG_KEY_LOW, '1);
    cfg_ch.valid <= 1'b0;
    send_block(CMD_ENC, '0, '0, 1'b0);
    drain();
    write_key(CFG_KEY_HIGH, 64'h8000000000000001);
    cfg_ch.valid <= 1'b0;
    send_block(CMD_DEC, '1, '0, 1'b0);

    // Random phases under new key loads; results stall at random except in phase 3.
    for (int p = 0; p < 6; p++) begin
      case (p)
        2: load_key('1);
        4: load_key('0);
        default: load_key({rand64(), rand64()});
      endcase
      stall_free <= (p == 3);
      run_random(280);
    end

    drain();
    $display("covered %0d encrypt and %0d decrypt items, %0d key register writes",
             enc_cnt, dec_cnt, key_writes);
    $display("keys: zero, all ones, standard vector, one-half changes and random keys");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/aes_pkg.sv
rtl/aes_if.sv
rtl/aes_cell.sv
rtl/aes128_block_cipher.sv
tb/aes128_block_cipher_checker.sv
tb/aes128_block_cipher_tb.sv
